[rtl/vm_branch_and_register_executor_defines.svh]
// Assertion macros shared by the executor RTL.
`ifndef VM_BRANCH_AND_REGISTER_EXECUTOR_DEFINES_SVH
`define VM_BRANCH_AND_REGISTER_EXECUTOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define VMBRE_ASSERT_SAME(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("executor check failed");

// Check that a condition implies another in the following cycle.
`define VMBRE_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("executor check failed");

`endif

[rtl/vmbre_pkg.sv]
`timescale 1ns / 1ps

package vmbre_pkg;

  localparam int ADDR_W        = 12;
  localparam int INSTR_W       = 16;
  localparam int DATA_W        = 8;
  localparam int REG_NUM_W     = 4;
  localparam int NUM_REGS      = 16;
  localparam int STACK_ENTRIES = 16;
  localparam int DEPTH_W       = $clog2(STACK_ENTRIES + 1);
  localparam int SIDX_W        = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  localparam logic [ADDR_W-1:0]  START_RESET = 12'h200;
  localparam logic [INSTR_W-1:0] RET_WORD    = 16'h00EE;

  // Opcodes (top nibble of the instruction word)
  localparam logic [3:0] OP_SYS    = 4'h0;
  localparam logic [3:0] OP_JUMP   = 4'h1;
  localparam logic [3:0] OP_CALL   = 4'h2;
  localparam logic [3:0] OP_SEQ_I  = 4'h3;
  localparam logic [3:0] OP_SNE_I  = 4'h4;
  localparam logic [3:0] OP_SEQ_R  = 4'h5;
  localparam logic [3:0] OP_LOAD   = 4'h6;
  localparam logic [3:0] OP_ADD    = 4'h7;
  localparam logic [3:0] OP_SNE_R  = 4'h9;
  localparam logic [3:0] OP_LDIDX  = 4'hA;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } status_t;

endpackage

[rtl/vmbre_instr_if.sv]
`timescale 1ns / 1ps

interface vmbre_instr_if
  import vmbre_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

[rtl/vmbre_result_if.sv]
`timescale 1ns / 1ps

interface vmbre_result_if
  import vmbre_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    pc_out;
  logic [ADDR_W-1:0]    index_out;
  logic [1:0]           status;
  logic                 reg_write;
  logic [REG_NUM_W-1:0] reg_num;
  logic [DATA_W-1:0]    reg_value;
  logic                 skipped;

  modport source (output valid, output pc_out, output index_out, output status,
                  output reg_write, output reg_num, output reg_value, output skipped,
                  input ready);
  modport sink   (input valid, input pc_out, input index_out, input status,
                  input reg_write, input reg_num, input reg_value, input skipped,
                  output ready);
endinterface

[rtl/vm_branch_and_register_executor.sv]
`timescale 1ns / 1ps
// Instruction executor for a small 8-bit virtual machine.
// Channels: instr_ch carries one 16-bit instruction word per transfer;
// result_ch returns one result per instruction (new program counter,
// index register, status, register write and skip flag).
// cfg_wr_en / cfg_wr_data load the start address; the program counter is
// loaded with it at the same edge. Write it only while the block is idle.
// An instruction passes from the instruction register through decode and
// execute logic into the result register, where a result_ch stall holds it.
// Throughput: one instruction per cycle while result_ch is ready. General
// registers are read at transfer in and forwarded from the executing item.
// Reset: program counter 0x200, index 0, all general registers read as zero
// (per-register valid bits), return stack empty, both stages empty.
// Stall: when result_ch is not ready the result holds, the pending
// instruction waits in its register and instr_ch drops ready once both
// stages are full.
module vm_branch_and_register_executor
  import vmbre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  vmbre_instr_if.sink       instr_ch,
  vmbre_result_if.source    result_ch
);

`include "vm_branch_and_register_executor_defines.svh"

  // Architectural state
  logic [ADDR_W-1:0]  pc;
  logic [ADDR_W-1:0]  index_reg;
  logic [DEPTH_W-1:0] depth;
  logic [ADDR_W-1:0]  stack [STACK_ENTRIES];
  logic [DATA_W-1:0]  regs  [NUM_REGS];
  logic [NUM_REGS-1:0] reg_vld;

  // Instruction stage
  logic               s1_valid;
  logic [INSTR_W-1:0] s1_instr;
  logic [DATA_W-1:0]  s1_rx;
  logic [DATA_W-1:0]  s1_ry;

  // Result stage
  logic                 res_valid;
  logic [ADDR_W-1:0]    res_pc;
  logic [ADDR_W-1:0]    res_index;
  status_t              res_status;
  logic                 res_wr;
  logic [REG_NUM_W-1:0] res_num;
  logic [DATA_W-1:0]    res_val;
  logic                 res_skip;

  // Execute outputs
  logic [ADDR_W-1:0]    pc_next;
  logic [ADDR_W-1:0]    index_next;
  logic [DEPTH_W-1:0]   depth_next;
  status_t              status_next;
  logic                 wr_next;
  logic [REG_NUM_W-1:0] num_next;
  logic [DATA_W-1:0]    val_next;
  logic                 skip_next;
  logic                 push;

  logic [3:0]           op;
  logic [REG_NUM_W-1:0] x_num;
  logic [DATA_W-1:0]    nn;
  logic [ADDR_W-1:0]    nnn;
  logic [ADDR_W-1:0]    pc_plus2;
  logic [DEPTH_W-1:0]   depth_dec;

  logic in_fire;
  logic exec_fire;
  logic [REG_NUM_W-1:0] in_x;
  logic [REG_NUM_W-1:0] in_y;

  assign exec_fire      = s1_valid && (!res_valid || result_ch.ready);
  assign instr_ch.ready = !s1_valid || exec_fire;
  assign in_fire        = instr_ch.valid && instr_ch.ready;
  assign in_x           = instr_ch.instr[11:8];
  assign in_y           = instr_ch.instr[7:4];

  assign op        = s1_instr[15:12];
  assign x_num     = s1_instr[11:8];
  assign nn        = s1_instr[7:0];
  assign nnn       = s1_instr[11:0];
  assign pc_plus2  = pc + ADDR_W'(2);
  assign depth_dec = depth - DEPTH_W'(1);

  // Decode and execute the held instruction
  always_comb begin
    pc_next     = pc_plus2;
    index_next  = index_reg;
    depth_next  = depth;
    status_next = ST_OK;
    wr_next     = 1'b0;
    num_next    = '0;
    val_next    = '0;
    skip_next   = 1'b0;
    push        = 1'b0;
    unique case (op)
      OP_SYS: begin
        pc_next = pc;
        if (s1_instr == RET_WORD) begin
          if (depth == '0) begin
            status_next = ST_UNDERFLOW;
          end else begin
            depth_next = depth_dec;
            pc_next    = stack[depth_dec[SIDX_W-1:0]];
          end
        end else begin
          status_next = ST_UNSUPPORTED;
        end
      end
      OP_JUMP: pc_next = nnn;
      OP_CALL: begin
        if (depth == DEPTH_W'(STACK_ENTRIES)) begin
          pc_next     = pc;
          status_next = ST_OVERFLOW;
        end else begin
          push       = 1'b1;
          depth_next = depth + DEPTH_W'(1);
          pc_next    = nnn;
        end
      end
      OP_SEQ_I: skip_next = (s1_rx == nn);
      OP_SNE_I: skip_next = (s1_rx != nn);
      OP_SEQ_R: skip_next = (s1_rx == s1_ry);
      OP_SNE_R: skip_next = (s1_rx != s1_ry);
      OP_LOAD: begin
        wr_next  = 1'b1;
        num_next = x_num;
        val_next = nn;
      end
      OP_ADD: begin
        wr_next  = 1'b1;
        num_next = x_num;
        val_next = s1_rx + nn;
      end
      OP_LDIDX: index_next = nnn;
      default: begin
        pc_next     = pc;
        status_next = ST_UNSUPPORTED;
      end
    endcase
    if (skip_next) begin
      pc_next = pc + ADDR_W'(4);
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= START_RESET;
      index_reg <= '0;
      depth     <= '0;
      reg_vld   <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pc <= cfg_wr_data;
      end else if (exec_fire) begin
        pc <= pc_next;
      end
      if (exec_fire) begin
        index_reg <= index_next;
        depth     <= depth_next;
        if (wr_next) begin
          reg_vld[num_next] <= 1'b1;
        end
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (exec_fire) begin
        s1_valid <= 1'b0;
      end
      if (exec_fire) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Write the return stack and general registers
  always_ff @(posedge clk) begin
    if (exec_fire && push) begin
      stack[depth[SIDX_W-1:0]] <= pc_plus2;
    end
    if (exec_fire && wr_next) begin
      regs[num_next] <= val_next;
    end
  end

  // Capture the instruction and read its operands, forwarding the executing write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr <= instr_ch.instr;
      if (exec_fire && wr_next && num_next == in_x) begin
        s1_rx <= val_next;
      end else begin
        s1_rx <= reg_vld[in_x] ? regs[in_x] : '0;
      end
      if (exec_fire && wr_next && num_next == in_y) begin
        s1_ry <= val_next;
      end else begin
        s1_ry <= reg_vld[in_y] ? regs[in_y] : '0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_pc     <= pc_next;
      res_index  <= index_next;
      res_status <= status_next;
      res_wr     <= wr_next;
      res_num    <= num_next;
      res_val    <= val_next;
      res_skip   <= skip_next;
    end
  end

  assign result_ch.valid     = res_valid;
  assign result_ch.pc_out    = res_pc;
  assign result_ch.index_out = res_index;
  assign result_ch.status    = res_status;
  assign result_ch.reg_write = res_wr;
  assign result_ch.reg_num   = res_num;
  assign result_ch.reg_value = res_val;
  assign result_ch.skipped   = res_skip;

  // Checks
  `VMBRE_ASSERT_SAME(a_depth_bound, clk, rst, 1'b1, depth <= DEPTH_W'(STACK_ENTRIES))
  `VMBRE_ASSERT_NEXT(a_overflow_flag, clk, rst,
    exec_fire && op == OP_CALL && depth == DEPTH_W'(STACK_ENTRIES),
    res_status == ST_OVERFLOW && $stable(depth))
  `VMBRE_ASSERT_SAME(a_no_write_zero, clk, rst, res_valid && !res_wr,
    res_num == '0 && res_val == '0)
  `VMBRE_ASSERT_NEXT(a_skip_pc, clk, rst, exec_fire && skip_next && !cfg_wr_en,
    pc == $past(pc) + ADDR_W'(4))

endmodule
